### src/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// Trial division prime test package
// Shared constants and types for the trial division prime test core.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int unsigned NUM_BITS_DEF = 32;
    localparam int unsigned OUT_DATA_W   = 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BOUND,
        ST_DIVIDE,
        ST_RESULT
    } t_state;

endpackage

### src/trial_division_prime_test_core.sv
// ----------------------------------------------------------------------------
// Trial division prime test core
// Reports whether an unsigned candidate is prime by trial division.
// ----------------------------------------------------------------------------
// One request at a time: the candidate is tried against divisors 2, 3, 4, ...
// while the square of the divisor does not exceed it. The square is kept up to
// date by adding 2k+1 per divisor, and each remainder comes from a bit-serial
// restoring divider that takes one candidate bit per cycle. Each divisor needs
// one bound check and NUM_BITS divide steps. A result waits in an output
// register, so the next request is taken while it is still pending.
module trial_division_prime_test_core
    import tdpt_pkg::*;
#(
    parameter int unsigned NUM_BITS = NUM_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // Bits from the lowest up: candidate, then zero padding.
    input  logic [((NUM_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // Bits from the lowest up: is_prime, then zero padding.
    output logic [OUT_DATA_W-1:0]               o_m_axis_tdata
);

    localparam int unsigned SQ_W  = NUM_BITS + 2;
    localparam int unsigned CNT_W = $clog2(NUM_BITS);

    t_state               r_state, n_state;
    logic [NUM_BITS-1:0]  r_n, n_n;
    logic [NUM_BITS-1:0]  r_k, n_k;
    logic [SQ_W-1:0]      r_sq, n_sq;
    logic [NUM_BITS-1:0]  r_shift, n_shift;
    logic [NUM_BITS-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_bit, n_out_bit;

    logic [NUM_BITS:0]    w_trial;
    logic [NUM_BITS:0]    w_diff;
    logic [NUM_BITS-1:0]  w_rem_next;
    logic                 w_in_acc;
    logic                 w_out_free;

    assign w_trial    = {r_rem, r_shift[NUM_BITS-1]};
    assign w_diff     = w_trial - {1'b0, r_k};
    assign w_rem_next = (w_trial >= {1'b0, r_k}) ? w_diff[NUM_BITS-1:0]
                                                 : w_trial[NUM_BITS-1:0];
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - 1){1'b0}}, r_out_bit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n       <= n_n;
        r_k       <= n_k;
        r_sq      <= n_sq;
        r_shift   <= n_shift;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_res     <= n_res;
        r_out_bit <= n_out_bit;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_k         = r_k;
        n_sq        = r_sq;
        n_shift     = r_shift;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_bit   = r_out_bit;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_n  = i_s_axis_tdata[NUM_BITS-1:0];
                    n_k  = NUM_BITS'(2);
                    n_sq = SQ_W'(4);
                    if (i_s_axis_tdata[NUM_BITS-1:1] == '0) begin
                        n_res   = 1'b0;
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_BOUND;
                    end
                end
            end
            ST_BOUND: begin
                if (r_sq > {2'b00, r_n}) begin
                    n_res   = 1'b1;
                    n_state = ST_RESULT;
                end else begin
                    n_shift = r_n;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                n_rem   = w_rem_next;
                n_shift = {r_shift[NUM_BITS-2:0], 1'b0};
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NUM_BITS - 1)) begin
                    if (w_rem_next == '0) begin
                        n_res   = 1'b0;
                        n_state = ST_RESULT;
                    end else begin
                        n_k     = r_k + NUM_BITS'(1);
                        n_sq    = r_sq + {1'b0, r_k, 1'b1};
                        n_state = ST_BOUND;
                    end
                end
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_bit   = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### src/tdpt_checker.sv
// ----------------------------------------------------------------------------
// Trial division prime test checker
// Port-level checks on the trial division prime test core.
// ----------------------------------------------------------------------------
module tdpt_checker
    import tdpt_pkg::*;
#(
    parameter int unsigned NUM_BITS = NUM_BITS_DEF
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_axis_tvalid,
    input logic                                o_s_axis_tready,
    input logic [((NUM_BITS + 7) / 8) * 8-1:0] i_s_axis_tdata,
    input logic                                o_m_axis_tvalid,
    input logic                                i_m_axis_tready,
    input logic [OUT_DATA_W-1:0]               o_m_axis_tdata
);

    logic [1:0] r_pend;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {1'b0, w_in_acc} - {1'b0, w_out_acc};
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("Result valid straight after reset.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pend != 2'd0))
        else $error("Result offered without an outstanding request.");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd2) |-> !o_s_axis_tready)
        else $error("Request taken while two are already outstanding.");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("Stalled result changed.");

    a_padding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[OUT_DATA_W-1:1] == '0))
        else $error("Result padding bits are not zero.");

endmodule

bind trial_division_prime_test_core tdpt_checker #(.NUM_BITS(NUM_BITS)) u_tdpt_checker (.*);
